// ===== rtl/core/crf_pkg.sv =====
// Shared constants and types for the clipped rectangle alpha fill block.
`timescale 1ns / 1ps
package crf_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int PIX_W          = 15;
    localparam int COLOR_W        = 32;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = COLOR_W / CHAN_W;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 5;
    localparam int CLIP_RESET_MAX = 32767;
    localparam int PIPE_DEPTH     = 4;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        REG_CLIP_LEFT   = 3'd0,
        REG_CLIP_TOP    = 3'd1,
        REG_CLIP_RIGHT  = 3'd2,
        REG_CLIP_BOTTOM = 3'd3,
        REG_FILL_COLOR  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               hit;
        logic [COLOR_W-1:0] dest;
    } clip_res_t;

endpackage

// ===== rtl/core/crf_if.sv =====
// Request channel interfaces: pixel input and pixel result.
`timescale 1ns / 1ps
interface crf_in_if #(
    parameter int COORD_BITS = crf_pkg::COORD_BITS_DEF
);
    import crf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] rect_left;
    logic [COORD_BITS-1:0] rect_top;
    logic [COORD_BITS-1:0] rect_right;
    logic [COORD_BITS-1:0] rect_bottom;
    logic [PIX_W-1:0]      pixel_x;
    logic [PIX_W-1:0]      pixel_y;
    logic [COLOR_W-1:0]    dst_argb;

    modport source (
        output valid, rect_left, rect_top, rect_right, rect_bottom,
               pixel_x, pixel_y, dst_argb,
        input  ready
    );
    modport sink (
        input  valid, rect_left, rect_top, rect_right, rect_bottom,
               pixel_x, pixel_y, dst_argb,
        output ready
    );
endinterface

interface crf_out_if;
    import crf_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] new_color;
    logic               write_enable;

    modport source (output valid, new_color, write_enable, input ready);
    modport sink (input valid, new_color, write_enable, output ready);
endinterface

// ===== rtl/core/clipped_rect_alpha_fill_top.sv =====
// Clipped rectangle fill with constant-alpha blend, one pixel per clock while pix_out is not stalled.
//
// pix_in carries one destination pixel per request: fill rectangle edges
// (left/top inclusive, right/bottom exclusive), pixel column and row, and the
// current ARGB8888 value. pix_out returns the new pixel value and a write
// enable that is set when the pixel lies inside the rectangle and the clip.
// Clip rectangle and fill color sit behind the APB port; write them only
// while no request is in flight.
// Throughput is one request per cycle while pix_out is not stalled: four register stages (intersection,
// containment test, channel products, sum/select) each take a new request
// whenever the stage after it advances.
// A stall on pix_out holds the result register and backs up stage by stage;
// pix_in.ready drops only once every stage holds a request.
// Reset clears the stage valid bits, sets the clip to 0..32767 on both axes
// and the fill color to 0.
`timescale 1ns / 1ps
module clipped_rect_alpha_fill_top #(
    parameter int COORD_BITS = crf_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    crf_in_if.sink                         pix_in,
    crf_out_if.source                      pix_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [crf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [crf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [crf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import crf_pkg::*;

    logic [COORD_BITS-1:0] clip_left, clip_top, clip_right, clip_bottom;
    logic [COLOR_W-1:0]    fill_color;
    clip_res_t             res;
    logic                  res_valid;
    logic                  res_ready;

    crf_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .clip_left   (clip_left),
        .clip_top    (clip_top),
        .clip_right  (clip_right),
        .clip_bottom (clip_bottom),
        .fill_color  (fill_color)
    );

    crf_clip #(
        .COORD_BITS (COORD_BITS)
    ) u_clip (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_in      (pix_in),
        .clip_left   (clip_left),
        .clip_top    (clip_top),
        .clip_right  (clip_right),
        .clip_bottom (clip_bottom),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready)
    );

    crf_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .fill_color (fill_color),
        .pix_out    (pix_out)
    );

endmodule

// ===== rtl/core/crf_regs.sv =====
// APB register file: clip rectangle and fill color.
`timescale 1ns / 1ps
module crf_regs #(
    parameter int COORD_BITS = crf_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [crf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [crf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [COORD_BITS-1:0]           clip_left,
    output logic [COORD_BITS-1:0]           clip_top,
    output logic [COORD_BITS-1:0]           clip_right,
    output logic [COORD_BITS-1:0]           clip_bottom,
    output logic [crf_pkg::COLOR_W-1:0]     fill_color
);
    import crf_pkg::*;

    localparam logic [COORD_BITS-1:0] EDGE_RESET = COORD_BITS'(CLIP_RESET_MAX);

    logic [COORD_BITS-1:0] clip_left_reg,   clip_left_next;
    logic [COORD_BITS-1:0] clip_top_reg,    clip_top_next;
    logic [COORD_BITS-1:0] clip_right_reg,  clip_right_next;
    logic [COORD_BITS-1:0] clip_bottom_reg, clip_bottom_next;
    logic [COLOR_W-1:0]    fill_color_reg,  fill_color_next;
    logic                  wr_en;
    reg_idx_t              idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_comb
    begin
        clip_left_next   = clip_left_reg;
        clip_top_next    = clip_top_reg;
        clip_right_next  = clip_right_reg;
        clip_bottom_next = clip_bottom_reg;
        fill_color_next  = fill_color_reg;
        if (wr_en)
        begin
            case (idx)
                REG_CLIP_LEFT:   clip_left_next   = pwdata[COORD_BITS-1:0];
                REG_CLIP_TOP:    clip_top_next    = pwdata[COORD_BITS-1:0];
                REG_CLIP_RIGHT:  clip_right_next  = pwdata[COORD_BITS-1:0];
                REG_CLIP_BOTTOM: clip_bottom_next = pwdata[COORD_BITS-1:0];
                REG_FILL_COLOR:  fill_color_next  = pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= EDGE_RESET;
            clip_bottom_reg <= EDGE_RESET;
            fill_color_reg  <= '0;
        end
        else
        begin
            clip_left_reg   <= clip_left_next;
            clip_top_reg    <= clip_top_next;
            clip_right_reg  <= clip_right_next;
            clip_bottom_reg <= clip_bottom_next;
            fill_color_reg  <= fill_color_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_CLIP_LEFT:   prdata = APB_DATA_W'(clip_left_reg);
            REG_CLIP_TOP:    prdata = APB_DATA_W'(clip_top_reg);
            REG_CLIP_RIGHT:  prdata = APB_DATA_W'(clip_right_reg);
            REG_CLIP_BOTTOM: prdata = APB_DATA_W'(clip_bottom_reg);
            REG_FILL_COLOR:  prdata = APB_DATA_W'(fill_color_reg);
            default:         prdata = '0;
        endcase
    end

    assign clip_left   = clip_left_reg;
    assign clip_top    = clip_top_reg;
    assign clip_right  = clip_right_reg;
    assign clip_bottom = clip_bottom_reg;
    assign fill_color  = fill_color_reg;

endmodule

// ===== rtl/core/crf_clip.sv =====
// Two pipeline stages: rectangle/clip intersection, then pixel containment test.
`timescale 1ns / 1ps
module crf_clip #(
    parameter int COORD_BITS = crf_pkg::COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    crf_in_if.sink                 pix_in,
    input  logic [COORD_BITS-1:0]  clip_left,
    input  logic [COORD_BITS-1:0]  clip_top,
    input  logic [COORD_BITS-1:0]  clip_right,
    input  logic [COORD_BITS-1:0]  clip_bottom,
    output crf_pkg::clip_res_t     res,
    output logic                   res_valid,
    input  logic                   res_ready
);
    import crf_pkg::*;

    // one extra bit so the unsigned pixel coordinates compare as positive values
    localparam int CMP_W = ((COORD_BITS > PIX_W) ? COORD_BITS : PIX_W) + 1;
    localparam int CEXT  = CMP_W - COORD_BITS;
    localparam int PEXT  = CMP_W - PIX_W;

    logic signed [CMP_W-1:0] rl, rt, rr, rb, cl, ct, cr, cb;
    logic signed [CMP_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [CMP_W-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic signed [CMP_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [COLOR_W-1:0]      dest1_reg;
    logic                    v1_reg, v2_reg;
    logic                    en1, en2;
    clip_res_t               res_reg, res_next;

    assign en2          = !v2_reg || res_ready;
    assign en1          = !v1_reg || en2;
    assign pix_in.ready = en1;

    assign rl = {{CEXT{pix_in.rect_left[COORD_BITS-1]}},   pix_in.rect_left};
    assign rt = {{CEXT{pix_in.rect_top[COORD_BITS-1]}},    pix_in.rect_top};
    assign rr = {{CEXT{pix_in.rect_right[COORD_BITS-1]}},  pix_in.rect_right};
    assign rb = {{CEXT{pix_in.rect_bottom[COORD_BITS-1]}}, pix_in.rect_bottom};
    assign cl = {{CEXT{clip_left[COORD_BITS-1]}},   clip_left};
    assign ct = {{CEXT{clip_top[COORD_BITS-1]}},    clip_top};
    assign cr = {{CEXT{clip_right[COORD_BITS-1]}},  clip_right};
    assign cb = {{CEXT{clip_bottom[COORD_BITS-1]}}, clip_bottom};

    always_comb
    begin
        sx_next = (rl > cl) ? rl : cl;
        sy_next = (rt > ct) ? rt : ct;
        ex_next = (rr < cr) ? rr : cr;
        ey_next = (rb < cb) ? rb : cb;
        px_next = {{PEXT{1'b0}}, pix_in.pixel_x};
        py_next = {{PEXT{1'b0}}, pix_in.pixel_y};
    end

    always_comb
    begin
        res_next.hit  = (sx_reg < ex_reg) && (sy_reg < ey_reg) &&
                        (px_reg >= sx_reg) && (px_reg < ex_reg) &&
                        (py_reg >= sy_reg) && (py_reg < ey_reg);
        res_next.dest = dest1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pix_in.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            dest1_reg <= pix_in.dst_argb;
        end
        if (en2)
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = v2_reg;

endmodule

// ===== rtl/core/crf_blend.sv =====
// Two pipeline stages: per-channel products, then sum and color select.
`timescale 1ns / 1ps
module crf_blend (
    input  logic                        clk,
    input  logic                        rst_n,
    input  crf_pkg::clip_res_t          res,
    input  logic                        res_valid,
    output logic                        res_ready,
    input  logic [crf_pkg::COLOR_W-1:0] fill_color,
    crf_out_if.source                   pix_out
);
    import crf_pkg::*;

    localparam int DPROD_W = 2 * CHAN_W + 1;
    localparam int SPROD_W = 2 * CHAN_W;

    logic [CHAN_W-1:0]  alpha;
    logic [CHAN_W:0]    neg;
    logic               v3_reg, v4_reg;
    logic               en3, en4;
    logic               hit3_reg;
    logic               opaque3_reg;
    logic [COLOR_W-1:0] dest3_reg;
    logic [COLOR_W-1:0] src3_reg;
    logic [DPROD_W-1:0] dprod_reg [NUM_CHAN];
    logic [DPROD_W-1:0] dprod_next [NUM_CHAN];
    logic [SPROD_W-1:0] sprod_reg [NUM_CHAN];
    logic [SPROD_W-1:0] sprod_next [NUM_CHAN];
    logic [COLOR_W-1:0] mix;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               we_reg;

    assign en4       = !v4_reg || pix_out.ready;
    assign en3       = !v3_reg || en4;
    assign res_ready = en3;

    // below opaque, a*256/255 equals a, so the source weight is alpha itself
    assign alpha = fill_color[COLOR_W-1 -: CHAN_W];
    assign neg   = (CHAN_W + 1)'(1 << CHAN_W) - {1'b0, alpha};

    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            dprod_next[i] = DPROD_W'(res.dest[i*CHAN_W +: CHAN_W]) * DPROD_W'(neg);
            sprod_next[i] = SPROD_W'(fill_color[i*CHAN_W +: CHAN_W]) * SPROD_W'(alpha);
        end
    end

    always_comb
    begin
        logic [DPROD_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            sum = dprod_reg[i] + DPROD_W'(sprod_reg[i]);
            mix[i*CHAN_W +: CHAN_W] = sum[CHAN_W +: CHAN_W];
        end
        if (!hit3_reg)
        begin
            color_next = dest3_reg;
        end
        else if (opaque3_reg)
        begin
            color_next = src3_reg;
        end
        else
        begin
            color_next = mix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                v3_reg <= res_valid;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            hit3_reg    <= res.hit;
            opaque3_reg <= (alpha == ALPHA_OPAQUE);
            dest3_reg   <= res.dest;
            src3_reg    <= fill_color;
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                dprod_reg[i] <= dprod_next[i];
                sprod_reg[i] <= sprod_next[i];
            end
        end
        if (en4)
        begin
            color_reg <= color_next;
            we_reg    <= hit3_reg;
        end
    end

    assign pix_out.valid        = v4_reg;
    assign pix_out.new_color    = color_reg;
    assign pix_out.write_enable = we_reg;

endmodule

// ===== rtl/core/crf_checker.sv =====
// Port-level checks for the fill block, bound to the top level.
`timescale 1ns / 1ps
module crf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [crf_pkg::COLOR_W-1:0] new_color,
    input logic                        write_enable
);
    import crf_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_acc, out_acc;

    assign in_acc  = in_valid & in_ready;
    assign out_acc = out_valid & out_ready;

    // requests in flight
    always_comb
    begin
        cnt_next = cnt_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_color) && $stable(write_enable))
        else $error("result changed while stalled");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is taken");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("result without a request in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more requests in flight than stages");

endmodule

bind clipped_rect_alpha_fill_top crf_checker u_crf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pix_in.valid),
    .in_ready     (pix_in.ready),
    .out_valid    (pix_out.valid),
    .out_ready    (pix_out.ready),
    .new_color    (pix_out.new_color),
    .write_enable (pix_out.write_enable)
);
